// File: hw/rtl/tlpf_pkg.sv
package tlpf_pkg;

   // Field widths
   localparam int CMD_W    = 2;
   localparam int ADDR_W   = 14;
   localparam int WORD_W   = 16;
   localparam int PIXEL_W  = 9;
   localparam int COLOUR_W = 15;
   localparam int INDEX_W  = 4;
   localparam int BANK_W   = 3;
   localparam int TILE_W   = 10;
   localparam int SUBPIX_W = 3;

   // Store geometry
   localparam int MAP_WORDS  = 4096;
   localparam int MAP_AW     = 12;
   localparam int MAP_TILES  = 64;
   localparam int TILE_WORDS = 16;
   localparam int TILE_ROWS  = 8;

   // Parameter defaults
   localparam int TILE_COUNT_DEFAULT      = 1024;
   localparam int PALETTE_COLOURS_DEFAULT = 128;

   // Command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_MAP_WRITE  = 2'd0,
      CMD_CHAR_WRITE = 2'd1,
      CMD_PAL_WRITE  = 2'd2,
      CMD_FETCH      = 2'd3
   } cmd_type;

   // Tilemap entry layout
   typedef struct packed {
      logic              vflip;
      logic              hflip;
      logic              priority_bit;
      logic [BANK_W-1:0] bank;
      logic [TILE_W-1:0] tile;
   } map_entry_type;

endpackage

// File: hw/rtl/tlpf_if.sv
// Command word channel
interface tlpf_req_if;
   import tlpf_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [ADDR_W-1:0]   address;
   logic [WORD_W-1:0]   write_data;
   logic [PIXEL_W-1:0]  pixel_x;
   logic [PIXEL_W-1:0]  pixel_y;

   modport source (output valid, cmd, address, write_data, pixel_x, pixel_y, input ready);
   modport sink   (input valid, cmd, address, write_data, pixel_x, pixel_y, output ready);
endinterface

// Pixel result channel
interface tlpf_rsp_if;
   import tlpf_pkg::*;

   logic                valid;
   logic                ready;
   logic [INDEX_W-1:0]  colour_index;
   logic [BANK_W-1:0]   palette_bank;
   logic                opaque;
   logic [COLOUR_W-1:0] pixel_colour;
   logic [TILE_W-1:0]   tile_number;

   modport source (output valid, colour_index, palette_bank, opaque, pixel_colour,
                   tile_number, input ready);
   modport sink   (input valid, colour_index, palette_bank, opaque, pixel_colour,
                   tile_number, output ready);
endinterface

// File: hw/rtl/tlpf_ram.sv
module tlpf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
   end

   // Registered read, holds while not enabled
   always_ff @(posedge clock) begin
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

// File: hw/rtl/tlpf_tile_addr.sv
module tlpf_tile_addr #(
   parameter int TILE_COUNT = tlpf_pkg::TILE_COUNT_DEFAULT
) (
   input  tlpf_pkg::map_entry_type               entry,
   input  logic [tlpf_pkg::SUBPIX_W-1:0]         pixel_col,
   input  logic [tlpf_pkg::SUBPIX_W-1:0]         pixel_row,
   output logic [$clog2(TILE_COUNT*tlpf_pkg::TILE_ROWS)-1:0] char_address,
   output logic [tlpf_pkg::SUBPIX_W-1:0]         bit_select
);
   import tlpf_pkg::*;

   localparam int CHAR_AW    = $clog2(TILE_COUNT * TILE_ROWS);
   localparam int TILE_STEPS = $clog2((2 ** TILE_W) / TILE_COUNT) + 1;
   localparam int REM_W      = TILE_W + 2;

   logic [REM_W-1:0]    tile_rem;
   logic [SUBPIX_W-1:0] row_sel;

   // Tile number modulo tile count: restoring subtract of shifted count
   always_comb begin
      tile_rem = REM_W'(entry.tile);
      for (int k = TILE_STEPS - 1; k >= 0; k--) begin
         if (tile_rem >= (REM_W'(TILE_COUNT) << k)) begin
            tile_rem = tile_rem - (REM_W'(TILE_COUNT) << k);
         end
      end
   end

   // Flips: 7 - n is the bitwise inverse on three bits
   assign row_sel      = entry.vflip ? ~pixel_row : pixel_row;
   assign bit_select   = entry.hflip ? pixel_col : ~pixel_col;
   assign char_address = CHAR_AW'({tile_rem[TILE_W-1:0], row_sel});

endmodule

// File: hw/rtl/tile_layer_pixel_fetch_unit.sv
// Channel   Dir  Handshake      Word
// req_in    in   valid/ready    cmd, address, write_data, pixel_x, pixel_y
// rsp_out   out  valid/ready    colour_index, palette_bank, opaque, pixel_colour, tile_number
// csr_*     in   write enable   backdrop colour, 15 bits
//
// One word enters per cycle while no result waits; a fetch result passes stages 1 to 3 and then the result register.
// Three chained memory reads set the depth: tilemap, character rows, palette.
// Each store is written at the stage where it is read, so words keep their order.
// A stalled result holds the whole pipeline and req_in.ready drops.
// Synchronous reset empties the pipeline and clears the backdrop colour.
module tile_layer_pixel_fetch_unit #(
   parameter int TILE_COUNT      = tlpf_pkg::TILE_COUNT_DEFAULT,
   parameter int PALETTE_COLOURS = tlpf_pkg::PALETTE_COLOURS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   tlpf_req_if.sink                        req_in,
   tlpf_rsp_if.source                      rsp_out,
   input  logic                            csr_write_enable,
   input  logic [tlpf_pkg::COLOUR_W-1:0]   csr_write_data
);
   import tlpf_pkg::*;

   localparam int CHAR_DEPTH = TILE_COUNT * TILE_ROWS;
   localparam int CHAR_AW    = $clog2(CHAR_DEPTH);
   localparam int PAL_AW     = $clog2(PALETTE_COLOURS);
   localparam int PAL_STEPS  = $clog2((2 ** (BANK_W + INDEX_W)) / PALETTE_COLOURS) + 1;
   localparam int PAL_REM_W  = BANK_W + INDEX_W + 3;

   logic advance;
   logic accept;

   // Stage 0: tile coordinate and tilemap access
   logic [MAP_AW-1:0] map_raddr;
   logic [6:0]        tx_raw, ty_raw, tx, ty;
   logic              map_we;
   logic              map_re;
   logic [WORD_W-1:0] map_rdata;

   // Stage 1
   logic                s1_valid_ff;
   cmd_type             s1_cmd_ff;
   logic [ADDR_W-1:0]   s1_address_ff;
   logic [WORD_W-1:0]   s1_data_ff;
   logic [SUBPIX_W-1:0] s1_px_ff;
   logic [SUBPIX_W-1:0] s1_py_ff;
   map_entry_type       s1_entry;
   logic [CHAR_AW-1:0]  char_raddr;
   logic [CHAR_AW-1:0]  char_waddr;
   logic [SUBPIX_W-1:0] s1_bit_select;
   logic                char_we;
   logic                char_re;
   logic [WORD_W-1:0]   char_lo_rdata;
   logic [WORD_W-1:0]   char_hi_rdata;

   // Stage 2
   logic                s2_valid_ff;
   cmd_type             s2_cmd_ff;
   logic [ADDR_W-1:0]   s2_address_ff;
   logic [WORD_W-1:0]   s2_data_ff;
   logic [BANK_W-1:0]   s2_bank_ff;
   logic [TILE_W-1:0]   s2_tile_ff;
   logic [SUBPIX_W-1:0] s2_bit_select_ff;
   logic [INDEX_W-1:0]  s2_index;
   logic [PAL_REM_W-1:0] pal_rem;
   logic                pal_we;
   logic                pal_re;
   logic [COLOUR_W-1:0] pal_rdata;

   // Stage 3
   logic                s3_valid_ff;
   logic [INDEX_W-1:0]  s3_index_ff;
   logic [BANK_W-1:0]   s3_bank_ff;
   logic [TILE_W-1:0]   s3_tile_ff;
   logic [COLOUR_W-1:0] s3_colour;

   // Result register and backdrop
   logic                rsp_valid_ff;
   logic [INDEX_W-1:0]  rsp_index_ff;
   logic [BANK_W-1:0]   rsp_bank_ff;
   logic                rsp_opaque_ff;
   logic [COLOUR_W-1:0] rsp_colour_ff;
   logic [TILE_W-1:0]   rsp_tile_ff;
   logic [COLOUR_W-1:0] backdrop_ff;

   // Whole pipeline moves unless a result waits
   assign advance      = !rsp_valid_ff || rsp_out.ready;
   assign accept       = req_in.valid && advance;
   assign req_in.ready = advance;

   // Quadrant addressing, tile coordinate wraps once at most
   assign tx_raw = {1'b0, req_in.pixel_x[PIXEL_W-1:SUBPIX_W]};
   assign ty_raw = {1'b0, req_in.pixel_y[PIXEL_W-1:SUBPIX_W]};
   assign tx = (tx_raw >= 7'(MAP_TILES)) ? tx_raw - 7'(MAP_TILES) : tx_raw;
   assign ty = (ty_raw >= 7'(MAP_TILES)) ? ty_raw - 7'(MAP_TILES) : ty_raw;
   assign map_raddr = {ty[5], tx[5], ty[4:0], tx[4:0]};

   assign map_we = accept && (req_in.cmd == CMD_MAP_WRITE) &&
                   (req_in.address < ADDR_W'(MAP_WORDS));
   assign map_re = accept && (req_in.cmd == CMD_FETCH);

   tlpf_ram #(.WIDTH(WORD_W), .DEPTH(MAP_WORDS)) u_map_ram (
      .clock         (clock),
      .write_enable  (map_we),
      .write_address (req_in.address[MAP_AW-1:0]),
      .write_data    (req_in.write_data),
      .read_enable   (map_re),
      .read_address  (map_raddr),
      .read_data     (map_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff     <= cmd_type'(req_in.cmd);
         s1_address_ff <= req_in.address;
         s1_data_ff    <= req_in.write_data;
         s1_px_ff      <= req_in.pixel_x[SUBPIX_W-1:0];
         s1_py_ff      <= req_in.pixel_y[SUBPIX_W-1:0];
      end
   end

   // Stage 1: flips and character row access
   assign s1_entry = map_entry_type'(map_rdata);

   tlpf_tile_addr #(.TILE_COUNT(TILE_COUNT)) u_tile_addr (
      .entry        (s1_entry),
      .pixel_col    (s1_px_ff),
      .pixel_row    (s1_py_ff),
      .char_address (char_raddr),
      .bit_select   (s1_bit_select)
   );

   // Rows 0..7 hold planes 0/1, rows 8..15 planes 2/3: one memory each
   assign char_we = advance && s1_valid_ff && (s1_cmd_ff == CMD_CHAR_WRITE) &&
                    ({1'b0, s1_address_ff} < (ADDR_W + 1)'(TILE_COUNT * TILE_WORDS));
   assign char_re = advance && s1_valid_ff && (s1_cmd_ff == CMD_FETCH);
   assign char_waddr = CHAR_AW'({s1_address_ff[ADDR_W-1:4], s1_address_ff[2:0]});

   tlpf_ram #(.WIDTH(WORD_W), .DEPTH(CHAR_DEPTH)) u_char_lo_ram (
      .clock         (clock),
      .write_enable  (char_we && !s1_address_ff[3]),
      .write_address (char_waddr),
      .write_data    (s1_data_ff),
      .read_enable   (char_re),
      .read_address  (char_raddr),
      .read_data     (char_lo_rdata)
   );

   tlpf_ram #(.WIDTH(WORD_W), .DEPTH(CHAR_DEPTH)) u_char_hi_ram (
      .clock         (clock),
      .write_enable  (char_we && s1_address_ff[3]),
      .write_address (char_waddr),
      .write_data    (s1_data_ff),
      .read_enable   (char_re),
      .read_address  (char_raddr),
      .read_data     (char_hi_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_cmd_ff        <= s1_cmd_ff;
         s2_address_ff    <= s1_address_ff;
         s2_data_ff       <= s1_data_ff;
         s2_bank_ff       <= s1_entry.bank;
         s2_tile_ff       <= s1_entry.tile;
         s2_bit_select_ff <= s1_bit_select;
      end
   end

   // Stage 2: gather bitplanes, palette access
   assign s2_index = {char_hi_rdata[{1'b1, s2_bit_select_ff}],
                      char_hi_rdata[{1'b0, s2_bit_select_ff}],
                      char_lo_rdata[{1'b1, s2_bit_select_ff}],
                      char_lo_rdata[{1'b0, s2_bit_select_ff}]};

   // Colour address modulo palette size
   always_comb begin
      pal_rem = PAL_REM_W'({s2_bank_ff, s2_index});
      for (int k = PAL_STEPS - 1; k >= 0; k--) begin
         if (pal_rem >= (PAL_REM_W'(PALETTE_COLOURS) << k)) begin
            pal_rem = pal_rem - (PAL_REM_W'(PALETTE_COLOURS) << k);
         end
      end
   end

   assign pal_we = advance && s2_valid_ff && (s2_cmd_ff == CMD_PAL_WRITE) &&
                   (s2_address_ff < ADDR_W'(PALETTE_COLOURS));
   assign pal_re = advance && s2_valid_ff && (s2_cmd_ff == CMD_FETCH);

   tlpf_ram #(.WIDTH(COLOUR_W), .DEPTH(PALETTE_COLOURS)) u_pal_ram (
      .clock         (clock),
      .write_enable  (pal_we),
      .write_address (s2_address_ff[PAL_AW-1:0]),
      .write_data    (s2_data_ff[COLOUR_W-1:0]),
      .read_enable   (pal_re),
      .read_address  (pal_rem[PAL_AW-1:0]),
      .read_data     (pal_rdata)
   );

   // Only fetches go on past stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff && (s2_cmd_ff == CMD_FETCH);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_index_ff <= s2_index;
         s3_bank_ff  <= s2_bank_ff;
         s3_tile_ff  <= s2_tile_ff;
      end
   end

   // Stage 3: backdrop for index zero
   assign s3_colour = (s3_index_ff != '0) ? pal_rdata : backdrop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_index_ff  <= s3_index_ff;
         rsp_bank_ff   <= s3_bank_ff;
         rsp_opaque_ff <= (s3_index_ff != '0);
         rsp_colour_ff <= s3_colour;
         rsp_tile_ff   <= s3_tile_ff;
      end
   end

   // Backdrop register
   always_ff @(posedge clock) begin
      if (reset) begin
         backdrop_ff <= '0;
      end else if (csr_write_enable) begin
         backdrop_ff <= csr_write_data;
      end
   end

   assign rsp_out.valid        = rsp_valid_ff;
   assign rsp_out.colour_index = rsp_index_ff;
   assign rsp_out.palette_bank = rsp_bank_ff;
   assign rsp_out.opaque       = rsp_opaque_ff;
   assign rsp_out.pixel_colour = rsp_colour_ff;
   assign rsp_out.tile_number  = rsp_tile_ff;

   // A waiting result holds the input side
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_out.ready |-> !req_in.ready)
      else $error("word accepted while result stalled");

   // Transparent pixels carry the backdrop colour
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_opaque_ff |-> rsp_colour_ff == backdrop_ff)
      else $error("transparent pixel without backdrop colour");

   // No result appears without a fetch in the last stage
   assert property (@(posedge clock) disable iff (reset)
      advance && !s3_valid_ff |=> !rsp_valid_ff)
      else $error("result without a fetch");

   // Writes never reach stage 3
   assert property (@(posedge clock) disable iff (reset)
      advance && s2_valid_ff && (s2_cmd_ff != CMD_FETCH) |=> !s3_valid_ff)
      else $error("write word reached result stage");

   // Reset leaves the pipeline empty
   assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_valid_ff && !s2_valid_ff && !s3_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

// File: sim/tb.sv
module tb;
   import tlpf_pkg::*;

   localparam int CHAR_WORDS     = TILE_COUNT_DEFAULT * TILE_WORDS;
   localparam int IDLE_PERCENT   = 35;
   localparam int PHASE_WORDS    = 340;
   localparam int DRAIN_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   // One fetched pixel as it leaves the result channel
   typedef struct packed {
      logic [INDEX_W-1:0]  colour_index;
      logic [BANK_W-1:0]   palette_bank;
      logic                opaque;
      logic [COLOUR_W-1:0] pixel_colour;
      logic [TILE_W-1:0]   tile_number;
   } pixel_type;

   // Mirror of the three stores and the backdrop, plus the pixels still owed
   class pixel_fetch_tracker;
      logic [WORD_W-1:0]   map_words  [MAP_WORDS];
      logic [WORD_W-1:0]   char_words [CHAR_WORDS];
      logic [COLOUR_W-1:0] pal_words  [PALETTE_COLOURS_DEFAULT];
      bit                  map_written  [MAP_WORDS];
      bit                  char_written [CHAR_WORDS];
      bit                  pal_written  [PALETTE_COLOURS_DEFAULT];
      logic [COLOUR_W-1:0] backdrop;
      pixel_type           pending_pixels [$];
      int                  mismatch_count;

      function new();
         backdrop = '0;
         mismatch_count = 0;
      endfunction

      // Quadrant paging: four 32x32 pages, right half then bottom half
      function int map_word_of(logic [PIXEL_W-1:0] x, logic [PIXEL_W-1:0] y);
         int tx;
         int ty;
         int half;
         half = MAP_TILES / 2;
         tx = int'(x[PIXEL_W-1:SUBPIX_W]) % MAP_TILES;
         ty = int'(y[PIXEL_W-1:SUBPIX_W]) % MAP_TILES;
         return ((ty >= half) ? 2 : 0) * half * half + ((tx >= half) ? 1 : 0) * half * half
                + (ty % half) * half + (tx % half);
      endfunction

      // Character word holding planes 0/1 of the row; planes 2/3 sit TILE_ROWS on
      function int char_row_of(map_entry_type entry, logic [PIXEL_W-1:0] y);
         int sy;
         sy = entry.vflip ? (TILE_ROWS - 1) - int'(y[SUBPIX_W-1:0]) : int'(y[SUBPIX_W-1:0]);
         return (int'(entry.tile) % TILE_COUNT_DEFAULT) * TILE_WORDS + sy;
      endfunction

      function int palette_slot(logic [BANK_W-1:0] bank, logic [INDEX_W-1:0] index);
         return (int'(bank) * 16 + int'(index)) % PALETTE_COLOURS_DEFAULT;
      endfunction

      function pixel_type predict_pixel(logic [PIXEL_W-1:0] x, logic [PIXEL_W-1:0] y);
         map_entry_type entry;
         logic [WORD_W-1:0] lo;
         logic [WORD_W-1:0] hi;
         int row;
         int sx;
         int shift;
         pixel_type p;
         entry = map_words[map_word_of(x, y)];
         row = char_row_of(entry, y);
         lo = char_words[row];
         hi = char_words[row + TILE_ROWS];
         sx = entry.hflip ? (TILE_ROWS - 1) - int'(x[SUBPIX_W-1:0]) : int'(x[SUBPIX_W-1:0]);
         // leftmost pixel is bit 7 of each plane byte
         shift = (TILE_ROWS - 1) - sx;
         p.colour_index = {hi[shift + 8], hi[shift], lo[shift + 8], lo[shift]};
         p.palette_bank = entry.bank;
         p.opaque = (p.colour_index != '0);
         p.pixel_colour = p.opaque ? pal_words[palette_slot(entry.bank, p.colour_index)]
                                   : backdrop;
         p.tile_number = entry.tile;
         return p;
      endfunction

      // Accepted command word: update a store, or queue the pixel a fetch owes
      function void note_word(cmd_type cmd, logic [ADDR_W-1:0] address,
                              logic [WORD_W-1:0] data,
                              logic [PIXEL_W-1:0] x, logic [PIXEL_W-1:0] y);
         case (cmd)
            CMD_MAP_WRITE: begin
               if (address < MAP_WORDS) begin
                  map_words[address] = data;
                  map_written[address] = 1'b1;
               end
            end
            CMD_CHAR_WRITE: begin
               if (address < CHAR_WORDS) begin
                  char_words[address] = data;
                  char_written[address] = 1'b1;
               end
            end
            CMD_PAL_WRITE: begin
               if (address < PALETTE_COLOURS_DEFAULT) begin
                  pal_words[address] = data[COLOUR_W-1:0];
                  pal_written[address] = 1'b1;
               end
            end
            default: pending_pixels.push_back(predict_pixel(x, y));
         endcase
      endfunction

      function void check_pixel(pixel_type seen);
         pixel_type want;
         if (pending_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected pixel: index %0h bank %0h opaque %0b colour %0h tile %0h",
                        seen.colour_index, seen.palette_bank, seen.opaque,
                        seen.pixel_colour, seen.tile_number);
            return;
         end
         want = pending_pixels.pop_front();
         if (seen.colour_index !== want.colour_index || seen.palette_bank !== want.palette_bank
             || seen.opaque !== want.opaque || seen.pixel_colour !== want.pixel_colour
             || seen.tile_number !== want.tile_number) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("pixel mismatch at %0t", $realtime);
               $display("  expected index %0h bank %0h opaque %0b colour %0h tile %0h",
                        want.colour_index, want.palette_bank, want.opaque,
                        want.pixel_colour, want.tile_number);
               $display("  actual   index %0h bank %0h opaque %0b colour %0h tile %0h",
                        seen.colour_index, seen.palette_bank, seen.opaque,
                        seen.pixel_colour, seen.tile_number);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable;
   logic [COLOUR_W-1:0] csr_write_data;
   logic take_pixel = 1'b0;
   bit steady_flow = 1'b0;
   int words_sent = 0;
   int quiet_cycles = 0;
   pixel_type seen_pixel;
   pixel_fetch_tracker tracker = new();
   logic [COLOUR_W-1:0] backdrop_plan [5];

   tlpf_req_if req_bus ();
   tlpf_rsp_if rsp_bus ();

   tile_layer_pixel_fetch_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_in           (req_bus),
      .rsp_out          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Result side back-pressure
   always @(posedge clock) begin
      take_pixel <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end
   assign rsp_bus.ready = take_pixel;

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
         seen_pixel.colour_index = rsp_bus.colour_index;
         seen_pixel.palette_bank = rsp_bus.palette_bank;
         seen_pixel.opaque = rsp_bus.opaque;
         seen_pixel.pixel_colour = rsp_bus.pixel_colour;
         seen_pixel.tile_number = rsp_bus.tile_number;
         tracker.check_pixel(seen_pixel);
      end
   end

   // Watchdog: too long with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready === 1'b1)
          || (rsp_bus.valid === 1'b1 && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one command word, with random idle cycles in front of it
   task automatic send_word(input cmd_type cmd, input logic [ADDR_W-1:0] address,
                            input logic [WORD_W-1:0] data,
                            input logic [PIXEL_W-1:0] x, input logic [PIXEL_W-1:0] y);
      while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= cmd;
      req_bus.address <= address;
      req_bus.write_data <= data;
      req_bus.pixel_x <= x;
      req_bus.pixel_y <= y;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      tracker.note_word(cmd, address, data, x, y);
      words_sent++;
   endtask

   task automatic send_write(input cmd_type cmd, input int address, input logic [WORD_W-1:0] data);
      send_word(cmd, ADDR_W'(address), data, PIXEL_W'($urandom), PIXEL_W'($urandom));
   endtask

   task automatic send_fetch(input logic [PIXEL_W-1:0] x, input logic [PIXEL_W-1:0] y);
      send_word(CMD_FETCH, ADDR_W'($urandom), WORD_W'($urandom), x, y);
   endtask

   // Load whatever the pixel would read that has never been written
   task automatic prepare_pixel(input logic [PIXEL_W-1:0] x, input logic [PIXEL_W-1:0] y);
      int word;
      int row;
      int slot;
      map_entry_type entry;
      pixel_type p;
      word = tracker.map_word_of(x, y);
      if (!tracker.map_written[word])
         send_write(CMD_MAP_WRITE, word, WORD_W'($urandom));
      entry = tracker.map_words[word];
      row = tracker.char_row_of(entry, y);
      if (!tracker.char_written[row])
         send_write(CMD_CHAR_WRITE, row, WORD_W'($urandom));
      if (!tracker.char_written[row + TILE_ROWS])
         send_write(CMD_CHAR_WRITE, row + TILE_ROWS, WORD_W'($urandom));
      p = tracker.predict_pixel(x, y);
      slot = tracker.palette_slot(p.palette_bank, p.colour_index);
      if (p.opaque && !tracker.pal_written[slot])
         send_write(CMD_PAL_WRITE, slot, WORD_W'($urandom));
   endtask

   task automatic fetch_pixel(input logic [PIXEL_W-1:0] x, input logic [PIXEL_W-1:0] y);
      prepare_pixel(x, y);
      send_fetch(x, y);
   endtask

   // Stop sending, let every owed pixel arrive and the pipe settle
   task automatic drain;
      req_bus.valid <= 1'b0;
      while (tracker.pending_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_backdrop(input logic [COLOUR_W-1:0] colour);
      csr_write_enable <= 1'b1;
      csr_write_data <= colour;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.backdrop = colour;
   endtask

   // Random traffic: mostly prepared fetches, raster runs and rewrites, some noise
   task automatic random_phase(input int count);
      int stop_at;
      int pick;
      int run;
      logic [PIXEL_W-1:0] x;
      logic [PIXEL_W-1:0] y;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         x = PIXEL_W'($urandom);
         y = PIXEL_W'($urandom);
         if (pick < 50) begin
            fetch_pixel(x, y);
         end else if (pick < 72) begin
            // raster run: load first, then fetch back to back along the row
            run = $urandom_range(4, 24);
            for (int i = 0; i < run; i++)
               prepare_pixel(x + PIXEL_W'(i), y);
            for (int i = 0; i < run; i++)
               send_fetch(x + PIXEL_W'(i), y);
         end else if (pick < 86) begin
            // rewrite what a pixel reads just before fetching it again
            fetch_pixel(x, y);
            if ($urandom_range(0, 1))
               send_write(CMD_MAP_WRITE, tracker.map_word_of(x, y), WORD_W'($urandom));
            else
               send_write(CMD_CHAR_WRITE,
                          tracker.char_row_of(tracker.map_words[tracker.map_word_of(x, y)], y)
                          + TILE_ROWS * $urandom_range(0, 1), WORD_W'($urandom));
            fetch_pixel(x, y);
         end else begin
            // loose write, often outside its store
            case ($urandom_range(0, 2))
               0: send_write(CMD_MAP_WRITE, $urandom_range(0, 1) ? $urandom_range(0, 16383)
                             : $urandom_range(0, MAP_WORDS - 1), WORD_W'($urandom));
               1: send_write(CMD_CHAR_WRITE, $urandom_range(0, CHAR_WORDS - 1),
                             WORD_W'($urandom));
               default: send_write(CMD_PAL_WRITE, $urandom_range(0, 1)
                                   ? $urandom_range(0, 16383)
                                   : $urandom_range(0, PALETTE_COLOURS_DEFAULT - 1),
                                   WORD_W'($urandom));
            endcase
         end
      end
   endtask

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.cmd <= CMD_MAP_WRITE;
      req_bus.address <= '0;
      req_bus.write_data <= '0;
      req_bus.pixel_x <= '0;
      req_bus.pixel_y <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_backdrop(15'h7fff);

      // Directed: tile 1023 in bank 7 at the top-left, full and empty rows
      send_write(CMD_MAP_WRITE, 0, 16'h1fff);
      send_write(CMD_CHAR_WRITE, 16368, 16'hffff);
      send_write(CMD_CHAR_WRITE, 16376, 16'hffff);
      send_write(CMD_CHAR_WRITE, 16375, 16'h0000);
      send_write(CMD_CHAR_WRITE, 16383, 16'h0000);
      send_write(CMD_PAL_WRITE, 127, 16'hffff);
      fetch_pixel(9'd0, 9'd0);
      fetch_pixel(9'd7, 9'd7);
      // both flips at the bottom-right corner of the last quadrant
      send_write(CMD_MAP_WRITE, MAP_WORDS - 1, 16'hc3ff);
      send_write(CMD_PAL_WRITE, 15, 16'h2aaa);
      fetch_pixel(9'd511, 9'd511);
      fetch_pixel(9'd504, 9'd504);
      // writes past the end of their store are dropped
      send_write(CMD_MAP_WRITE, 16383, 16'h0000);
      send_write(CMD_PAL_WRITE, PALETTE_COLOURS_DEFAULT, 16'h0000);
      send_write(CMD_PAL_WRITE, 16383, 16'h0000);
      fetch_pixel(9'd511, 9'd511);
      // tile 0 with the priority bit, second quadrant
      send_write(CMD_MAP_WRITE, 1024, 16'h2000);
      send_write(CMD_CHAR_WRITE, 3, 16'h5aa5);
      send_write(CMD_CHAR_WRITE, 11, 16'hc33c);
      fetch_pixel(9'd261, 9'd3);
      // horizontal flip only, third quadrant
      send_write(CMD_MAP_WRITE, 2048, 16'h4fff);
      fetch_pixel(9'd0, 9'd256);
      fetch_pixel(9'd511, 9'd0);
      fetch_pixel(9'd0, 9'd511);

      backdrop_plan[0] = 15'h0000;
      backdrop_plan[1] = COLOUR_W'($urandom);
      backdrop_plan[2] = 15'h7fff;
      backdrop_plan[3] = COLOUR_W'($urandom);
      backdrop_plan[4] = 15'h5555;
      foreach (backdrop_plan[i]) begin
         drain();
         write_backdrop(backdrop_plan[i]);
         steady_flow = (i == 2);
         random_phase(PHASE_WORDS);
      end
      steady_flow = 1'b0;

      drain();
      if (tracker.mismatch_count == 0 && tracker.pending_pixels.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
